### src/snapshot_interpolation_buffer_core_defines.svh
// Assertion helpers for the snapshot interpolation buffer
`ifndef SNAPSHOT_INTERPOLATION_BUFFER_CORE_DEFINES_SVH
`define SNAPSHOT_INTERPOLATION_BUFFER_CORE_DEFINES_SVH

// Checked on every clock edge, suspended while reset is asserted
`define SIB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define SIB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/sib_pkg.sv
`default_nettype none

package sib_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned ANG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Front to back queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // Arithmetic widths
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W = 50;
  localparam int unsigned MAG_W  = 48;
  localparam int unsigned REM_W  = 10;
  localparam int unsigned EDIV_BITS = 4;

  localparam logic [REM_W:0] EXT_DIVISOR = 11'd1000;

  // Sequencer counts
  localparam logic [3:0] FRAC_STEP_LAST = 4'd15;
  localparam logic [3:0] EDIV_STEP_LAST = 4'd11;
  localparam logic [2:0] LERP_LAST      = 3'd5;
  localparam logic [2:0] EXT_LAST       = 3'd2;
  localparam logic [2:0] ANG_FIRST      = 3'd3;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RESET_DELAY = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RESET_LIMIT = 16'd500;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } sib_op_e;

  typedef enum logic [1:0] {
    MODE_NEWEST = 2'd0,
    MODE_INTERP = 2'd1,
    MODE_EXTRAP = 2'd2,
    MODE_HOLD   = 2'd3
  } sib_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPLAY_DELAY = 'd0,
    REG_EXTRAP_LIMIT = 'd1
  } sib_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_SLOT0,
    S_SCAN_RD,
    S_SCAN,
    S_FRAC,
    S_DIV,
    S_LMUL,
    S_LADD,
    S_EMUL,
    S_EABS,
    S_EDIV,
    S_EADD,
    S_OUT
  } sib_state_e;

  typedef struct packed {
    logic [TIME_W-1:0]         time_ms;
    logic [2:0][POS_W-1:0]     pos;
    logic [2:0][ANG_W-1:0]     ang;
    logic [2:0][POS_W-1:0]     vel;
  } sib_snap_t;

  // Queue entry: for a query, time_ms carries the replay time
  typedef struct packed {
    sib_op_e   op;
    logic      time_valid;
    sib_snap_t snap;
  } sib_item_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][ANG_W-1:0] ang;
    sib_mode_e             mode;
  } sib_pose_t;

endpackage

`default_nettype wire

### src/sib_ifs.sv
`default_nettype none

// Input item channel
interface sib_in_if;
  import sib_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [TIME_W-1:0]       time_ms;
  logic                    time_valid;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [ANG_W-1:0]        angle_pitch;
  logic [ANG_W-1:0]        angle_yaw;
  logic [ANG_W-1:0]        angle_roll;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;
  logic signed [POS_W-1:0] vel_z;

  modport source (
    output valid, operation, time_ms, time_valid, pos_x, pos_y, pos_z,
    output angle_pitch, angle_yaw, angle_roll, vel_x, vel_y, vel_z,
    input  ready
  );
  modport sink (
    input  valid, operation, time_ms, time_valid, pos_x, pos_y, pos_z,
    input  angle_pitch, angle_yaw, angle_roll, vel_x, vel_y, vel_z,
    output ready
  );
endinterface

// Result channel
interface sib_out_if;
  import sib_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic [ANG_W-1:0]        out_pitch;
  logic [ANG_W-1:0]        out_yaw;
  logic [ANG_W-1:0]        out_roll;
  logic [1:0]              mode;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z, out_pitch, out_yaw, out_roll, mode,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z, out_pitch, out_yaw, out_roll, mode,
    output ready
  );
endinterface

// Configuration write channel
interface sib_cfg_if;
  import sib_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/sib_queue.sv
`default_nettype none

module sib_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  sib_pkg::sib_item_t     push_item_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output sib_pkg::sib_item_t     pop_item_o,
  input  wire logic              pop_i
);
  import sib_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sib_item_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### src/sib_front.sv
`default_nettype none

module sib_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  sib_in_if.sink                            in_i,
  sib_cfg_if.sink                           cfg_i,
  output logic                              push_valid_o,
  output sib_pkg::sib_item_t                push_item_o,
  input  wire logic                         push_ready_i,
  output logic [sib_pkg::CFG_DATA_W-1:0]    limit_o
);
  import sib_pkg::*;

  logic [CFG_DATA_W-1:0] delay_q, delay_d;
  logic [CFG_DATA_W-1:0] limit_q, limit_d;

  // Register writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    delay_d = delay_q;
    limit_d = limit_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_REPLAY_DELAY: delay_d = cfg_i.data;
        REG_EXTRAP_LIMIT: limit_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= RESET_DELAY;
      limit_q <= RESET_LIMIT;
    end else begin
      delay_q <= delay_d;
      limit_q <= limit_d;
    end
  end

  assign limit_o = limit_q;

  // Classify the item and form the replay time for queries
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

  always_comb begin
    push_item_o.op         = sib_op_e'(in_i.operation);
    push_item_o.time_valid = in_i.time_valid;
    push_item_o.snap.time_ms = (in_i.operation == OP_QUERY) ?
                               in_i.time_ms - TIME_W'(delay_q) : in_i.time_ms;
    push_item_o.snap.pos[0] = in_i.pos_x;
    push_item_o.snap.pos[1] = in_i.pos_y;
    push_item_o.snap.pos[2] = in_i.pos_z;
    push_item_o.snap.ang[0] = in_i.angle_pitch;
    push_item_o.snap.ang[1] = in_i.angle_yaw;
    push_item_o.snap.ang[2] = in_i.angle_roll;
    push_item_o.snap.vel[0] = in_i.vel_x;
    push_item_o.snap.vel[1] = in_i.vel_y;
    push_item_o.snap.vel[2] = in_i.vel_z;
  end

endmodule

`default_nettype wire

### src/sib_back.sv
`default_nettype none

module sib_back #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        pop_valid_i,
  input  sib_pkg::sib_item_t               pop_item_i,
  output logic                             pop_o,
  input  wire logic [sib_pkg::CFG_DATA_W-1:0] limit_i,
  sib_out_if.source                        out_o
);
  import sib_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Snapshot ring; slot 0 sits at head_q, older slots below it
  sib_snap_t mem_q [DEPTH];
  sib_snap_t rdata_q;

  sib_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, head_next;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d, ptr_prev;
  logic [CW-1:0] idx_q, idx_d;
  logic          out_valid_q, out_load;
  sib_pose_t     out_pose_q;

  // Working registers
  logic                     tvalid_q, tvalid_d;
  logic [TIME_W-1:0]        replay_q, replay_d;
  sib_snap_t                hi_q, hi_d, lo_q, lo_d;
  logic [TIME_W-1:0]        rem_q, rem_d, den_q, den_d;
  logic [FRAC_W-1:0]        frac_q, frac_d;
  logic [3:0]               cnt_q, cnt_d;
  logic [2:0]               k_q, k_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [REM_W-1:0]         erem_q, erem_d;
  logic [CFG_DATA_W-1:0]    el_q, el_d;
  sib_pose_t                res_q, res_d;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [1:0]                pk, ak;
  logic [ANG_W-1:0]          da16;

  logic                      wr_en;
  logic                      more;
  logic [TIME_W-1:0]         elapsed, span;

  assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign ptr_prev  = (rd_ptr_q == '0) ? AW'(DEPTH - 1) : rd_ptr_q - 1'b1;
  assign pk = k_q[1:0];
  assign ak = 2'(k_q - ANG_FIRST);
  assign da16 = hi_q.ang[ak] - lo_q.ang[ak];

  // Operand select: lerp deltas times fraction, or velocity times elapsed
  always_comb begin
    if (state_q == S_EMUL) begin
      mul_a = MUL_A_W'($signed(lo_q.vel[pk]));
      mul_b = $signed({1'b0, el_q});
    end else begin
      if (k_q < ANG_FIRST) begin
        mul_a = MUL_A_W'($signed(hi_q.pos[pk])) - MUL_A_W'($signed(lo_q.pos[pk]));
      end else begin
        mul_a = MUL_A_W'($signed(da16));
      end
      mul_b = $signed({1'b0, frac_q});
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Scan continues while the slot is too new and an older one is filled
  assign more = ((CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(fill_q)) &&
                (rdata_q.time_ms > replay_q);
  assign elapsed = replay_q - rdata_q.time_ms;
  assign span    = hi_q.time_ms - lo_q.time_ms;

  // Sequencer
  always_comb begin
    logic [TIME_W:0]         r2;
    logic [REM_W:0]          er;
    logic [MAG_W-1:0]        em;
    logic signed [PROD_W-1:0] sh;
    logic [MAG_W-1:0]        step;

    state_d  = state_q;
    head_d   = head_q;
    fill_d   = fill_q;
    rd_ptr_d = rd_ptr_q;
    idx_d    = idx_q;
    tvalid_d = tvalid_q;
    replay_d = replay_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    rem_d    = rem_q;
    den_d    = den_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    prod_d   = prod_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    erem_d   = erem_q;
    el_d     = el_q;
    res_d    = res_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    r2   = {rem_q, 1'b0};
    er   = {1'b0, erem_q};
    em   = mag_q;
    sh   = prod_q >>> FRAC_W;
    step = neg_q ? -mag_q : mag_q;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_o = 1'b1;
          if (pop_item_i.op == OP_STORE) begin
            wr_en  = 1'b1;
            head_d = head_next;
            if (fill_q != CW'(DEPTH)) begin
              fill_d = fill_q + 1'b1;
            end
          end else begin
            tvalid_d = pop_item_i.time_valid;
            replay_d = pop_item_i.snap.time_ms;
            rd_ptr_d = head_q;
            idx_d    = '0;
            state_d  = S_RD0;
          end
        end
      end
      S_RD0: state_d = S_SLOT0;
      S_SLOT0: begin
        hi_d = rdata_q;
        lo_d = rdata_q;
        if (!tvalid_q || fill_q == '0) begin
          // Passthrough of the newest slot; an empty buffer reads as zero
          res_d.pos  = (fill_q == '0) ? '0 : rdata_q.pos;
          res_d.ang  = (fill_q == '0) ? '0 : rdata_q.ang;
          res_d.mode = MODE_NEWEST;
          state_d    = S_OUT;
        end else if (rdata_q.time_ms > replay_q) begin
          if (more) begin
            idx_d    = idx_q + 1'b1;
            rd_ptr_d = ptr_prev;
            state_d  = S_SCAN_RD;
          end else begin
            state_d = S_FRAC;
          end
        end else if (elapsed < TIME_W'(limit_i)) begin
          el_d    = elapsed[CFG_DATA_W-1:0];
          k_d     = '0;
          state_d = S_EMUL;
        end else begin
          res_d      = '0;
          res_d.mode = MODE_HOLD;
          state_d    = S_OUT;
        end
      end
      S_SCAN_RD: state_d = S_SCAN;
      S_SCAN: begin
        lo_d = rdata_q;
        if (more) begin
          hi_d     = rdata_q;
          idx_d    = idx_q + 1'b1;
          rd_ptr_d = ptr_prev;
          state_d  = S_SCAN_RD;
        end else begin
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        frac_d = '0;
        k_d    = '0;
        cnt_d  = '0;
        // Oldest slot still too new, or a degenerate span: fraction stays 0
        if (lo_q.time_ms <= replay_q && span > TIME_W'(1) && !span[TIME_W-1]) begin
          rem_d   = replay_q - lo_q.time_ms;
          den_d   = span;
          state_d = S_DIV;
        end else begin
          state_d = S_LMUL;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle
        if (r2 >= {1'b0, den_q}) begin
          r2     = r2 - {1'b0, den_q};
          frac_d = {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          frac_d = {frac_q[FRAC_W-2:0], 1'b0};
        end
        rem_d = r2[TIME_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == FRAC_STEP_LAST) begin
          state_d = S_LMUL;
        end
      end
      S_LMUL: begin
        prod_d  = mul_p;
        state_d = S_LADD;
      end
      S_LADD: begin
        // Arithmetic shift gives the floored quotient
        if (k_q < ANG_FIRST) begin
          res_d.pos[pk] = lo_q.pos[pk] + sh[POS_W-1:0];
        end else begin
          res_d.ang[ak] = lo_q.ang[ak] + sh[ANG_W-1:0];
        end
        if (k_q == LERP_LAST) begin
          res_d.mode = MODE_INTERP;
          state_d    = S_OUT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_LMUL;
        end
      end
      S_EMUL: begin
        prod_d  = mul_p;
        state_d = S_EABS;
      end
      S_EABS: begin
        neg_d   = prod_q[PROD_W-1];
        mag_d   = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
        erem_d  = '0;
        cnt_d   = '0;
        state_d = S_EDIV;
      end
      S_EDIV: begin
        // Divide magnitude by 1000, four quotient bits per cycle
        for (int j = 0; j < EDIV_BITS; j++) begin
          er = {er[REM_W-1:0], em[MAG_W-1]};
          em = {em[MAG_W-2:0], 1'b0};
          if (er >= EXT_DIVISOR) begin
            er    = er - EXT_DIVISOR;
            em[0] = 1'b1;
          end
        end
        mag_d  = em;
        erem_d = er[REM_W-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == EDIV_STEP_LAST) begin
          state_d = S_EADD;
        end
      end
      S_EADD: begin
        res_d.pos[pk] = lo_q.pos[pk] + step[POS_W-1:0];
        if (k_q == EXT_LAST) begin
          res_d.ang  = lo_q.ang;
          res_d.mode = MODE_EXTRAP;
          state_d    = S_OUT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_EMUL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    idx_q    <= idx_d;
    tvalid_q <= tvalid_d;
    replay_q <= replay_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    frac_q   <= frac_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    prod_q   <= prod_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    erem_q   <= erem_d;
    el_q     <= el_d;
    res_q    <= res_d;
    if (out_load) begin
      out_pose_q <= res_q;
    end
  end

  // Snapshot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[head_next] <= pop_item_i.snap;
    end
    rdata_q <= mem_q[rd_ptr_q];
  end

  // Result register
  assign out_o.valid     = out_valid_q;
  assign out_o.out_pos_x = out_pose_q.pos[0];
  assign out_o.out_pos_y = out_pose_q.pos[1];
  assign out_o.out_pos_z = out_pose_q.pos[2];
  assign out_o.out_pitch = out_pose_q.ang[0];
  assign out_o.out_yaw   = out_pose_q.ang[1];
  assign out_o.out_roll  = out_pose_q.ang[2];
  assign out_o.mode      = out_pose_q.mode;

endmodule

`default_nettype wire

### src/snapshot_interpolation_buffer_core.sv
// Snapshot interpolation buffer: keeps the last DEPTH pose snapshots newest
// first and answers pose queries at (time - replay delay) by passthrough,
// linear interpolation between the bracketing pair, velocity extrapolation,
// or hold. Items enter a two-entry queue and are served one at a time by a
// sequencer around a snapshot memory with one write and one registered read
// port, a shared 33x17 multiplier and two serial dividers. A store is written
// from the idle state; a query that passes through or holds reads only the
// newest slot; an interpolating query scans older slots (at most DEPTH-1,
// one memory read per slot) and divides out a fraction when the span allows;
// an extrapolating query runs three serial divisions by 1000, one per axis.
// The result then sits in an output register until taken.
`default_nettype none

module snapshot_interpolation_buffer_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sib_in_if.sink    in_i,
  sib_cfg_if.sink   cfg_i,
  sib_out_if.source out_o
);
  import sib_pkg::*;

  logic                  push_valid, push_ready;
  sib_item_t             push_item;
  logic                  pop_valid, pop;
  sib_item_t             pop_item;
  logic [CFG_DATA_W-1:0] limit;

  // Front: config registers and item classification
  sib_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready),
    .limit_o      (limit)
  );

  // Decoupling queue
  sib_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  // Back: snapshot store and pose engine
  sib_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .limit_i     (limit),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### src/sib_checker.sv
`default_nettype none
`include "snapshot_interpolation_buffer_core_defines.svh"

module sib_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [sib_pkg::POS_W-1:0]    out_pos_x_i,
  input wire logic [sib_pkg::POS_W-1:0]    out_pos_y_i,
  input wire logic [sib_pkg::POS_W-1:0]    out_pos_z_i,
  input wire logic [sib_pkg::ANG_W-1:0]    out_pitch_i,
  input wire logic [sib_pkg::ANG_W-1:0]    out_yaw_i,
  input wire logic [sib_pkg::ANG_W-1:0]    out_roll_i,
  input wire logic [1:0]                   mode_i
);
  import sib_pkg::*;

  // No result is offered on the cycle after a reset edge
  `SIB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i, "result valid after reset")

  // A stalled result stays valid and keeps its mode, x position and yaw
  `SIB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(mode_i) && $stable(out_pos_x_i) && $stable(out_yaw_i), "stalled result changed")

  // Hold results carry a zero pose
  `SIB_ASSERT(a_hold_zero, clk_i, rst_ni, out_valid_i && mode_i == MODE_HOLD |-> out_pos_x_i == '0 && out_pos_y_i == '0 && out_pos_z_i == '0 && out_pitch_i == '0 && out_yaw_i == '0 && out_roll_i == '0, "hold pose not zero")

endmodule

bind snapshot_interpolation_buffer_core sib_checker u_sib_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pos_x_i (out_o.out_pos_x),
  .out_pos_y_i (out_o.out_pos_y),
  .out_pos_z_i (out_o.out_pos_z),
  .out_pitch_i (out_o.out_pitch),
  .out_yaw_i   (out_o.out_yaw),
  .out_roll_i  (out_o.out_roll),
  .mode_i      (out_o.mode)
);

`default_nettype wire

### dv/tb_sib_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Testbench-side copy of nothing: the RTL interfaces are used directly.
// This file holds the pose expectation record shared by the scoreboard.
package tb_sib_pkg;
  import sib_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] pitch, yaw, roll;
    sib_mode_e   mode;
  } pose_exp_t;
endpackage

`default_nettype wire

### dv/tb_snapshot_interpolation_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Pose predictor and pending-pose store
class pose_scoreboard;
  tb_sib_pkg::pose_exp_t pending_poses[$];
  logic [63:0] t_hist[16];
  logic [31:0] pos_hist[16][3];
  logic [15:0] ang_hist[16][3];
  logic [31:0] vel_hist[16][3];
  int unsigned fill;
  logic [15:0] delay_ms;
  logic [15:0] limit_ms;
  int unsigned errors;

  function new();
    fill = 0;
    delay_ms = 16'd100;
    limit_ms = 16'd500;
    errors = 0;
    foreach (t_hist[i]) begin
      t_hist[i] = '0;
      for (int j = 0; j < 3; j++) begin
        pos_hist[i][j] = '0;
        ang_hist[i][j] = '0;
        vel_hist[i][j] = '0;
      end
    end
  endfunction

  function void write_reg(sib_pkg::sib_reg_e idx, logic [15:0] d);
    if (idx == sib_pkg::REG_REPLAY_DELAY) delay_ms = d;
    else if (idx == sib_pkg::REG_EXTRAP_LIMIT) limit_ms = d;
  endfunction

  static function longint fdiv16(longint p);
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  // Accepted input: shift in a snapshot or predict a pose
  function void note_item(logic op, logic [63:0] t, logic tv, logic [31:0] p[3],
                          logic [15:0] a[3], logic [31:0] v[3]);
    tb_sib_pkg::pose_exp_t e;
    logic [63:0] replay, span, elapsed, den, r;
    logic [15:0] q, da16;
    int unsigned i, lo, hi;
    longint l, d, da, st;
    if (op == sib_pkg::OP_STORE) begin
      for (int k = 15; k > 0; k--) begin
        t_hist[k] = t_hist[k-1];
        pos_hist[k] = pos_hist[k-1];
        ang_hist[k] = ang_hist[k-1];
        vel_hist[k] = vel_hist[k-1];
      end
      t_hist[0] = t;
      pos_hist[0] = p;
      ang_hist[0] = a;
      vel_hist[0] = v;
      if (fill < 16) fill++;
      return;
    end
    if (!tv || fill == 0) begin
      e = '{pos_hist[0][0], pos_hist[0][1], pos_hist[0][2],
            ang_hist[0][0], ang_hist[0][1], ang_hist[0][2], sib_pkg::MODE_NEWEST};
      pending_poses.push_back(e);
      return;
    end
    replay = t - {48'd0, delay_ms};
    if (t_hist[0] > replay) begin
      i = 0;
      while (i + 1 < fill && t_hist[i] > replay) i++;
      lo = i;
      hi = (i > 0) ? i - 1 : 0;
      span = t_hist[hi] - t_hist[lo];
      q = '0;
      if (t_hist[lo] <= replay && span > 1 && !span[63]) begin
        r = replay - t_hist[lo];
        den = span;
        for (int k = 0; k < 16; k++) begin
          r = r << 1;
          q = q << 1;
          if (r >= den) begin
            r -= den;
            q[0] = 1'b1;
          end
        end
      end
      e.mode = sib_pkg::MODE_INTERP;
      for (int j = 0; j < 3; j++) begin
        l = longint'($signed(pos_hist[lo][j]));
        d = longint'($signed(pos_hist[hi][j])) - l;
        da16 = ang_hist[hi][j] - ang_hist[lo][j];
        da = longint'($signed(da16));
        l = l + fdiv16(d * longint'({1'b0, q}));
        da = longint'({1'b0, ang_hist[lo][j]}) + fdiv16(da * longint'({1'b0, q}));
        case (j)
          0: begin e.px = l[31:0]; e.pitch = da[15:0]; end
          1: begin e.py = l[31:0]; e.yaw = da[15:0]; end
          default: begin e.pz = l[31:0]; e.roll = da[15:0]; end
        endcase
      end
    end else begin
      elapsed = replay - t_hist[0];
      if (elapsed < {48'd0, limit_ms}) begin
        e.mode = sib_pkg::MODE_EXTRAP;
        e.pitch = ang_hist[0][0];
        e.yaw = ang_hist[0][1];
        e.roll = ang_hist[0][2];
        for (int j = 0; j < 3; j++) begin
          st = (longint'($signed(vel_hist[0][j])) * longint'(elapsed)) / 1000;
          l = longint'(pos_hist[0][j]) + st;
          case (j)
            0: e.px = l[31:0];
            1: e.py = l[31:0];
            default: e.pz = l[31:0];
          endcase
        end
      end else begin
        e = '{'0, '0, '0, '0, '0, '0, sib_pkg::MODE_HOLD};
      end
    end
    pending_poses.push_back(e);
  endfunction

  // Accepted result against the oldest pending pose
  function void check_pose(tb_sib_pkg::pose_exp_t got);
    tb_sib_pkg::pose_exp_t e;
    if (pending_poses.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected pose mode=%0d", got.mode);
      return;
    end
    e = pending_poses.pop_front();
    if (e.px !== got.px || e.py !== got.py || e.pz !== got.pz || e.pitch !== got.pitch ||
        e.yaw !== got.yaw || e.roll !== got.roll || e.mode !== got.mode) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: pose exp %h %h %h %h %h %h %0d got %h %h %h %h %h %h %0d",
                 e.px, e.py, e.pz, e.pitch, e.yaw, e.roll, e.mode,
                 got.px, got.py, got.pz, got.pitch, got.yaw, got.roll, got.mode);
    end
  endfunction
endclass

module tb_snapshot_interpolation_buffer_core;
  import sib_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sib_in_if  in_ch();
  sib_cfg_if cfg_ch();
  sib_out_if out_ch();

  snapshot_interpolation_buffer_core #(.DEPTH(16)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  pose_scoreboard poses = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned idle_cycles = 0;
  logic [63:0] now_ms = 64'd5000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_STORE;
    in_ch.time_ms = '0;
    in_ch.time_valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.angle_pitch = '0;
    in_ch.angle_yaw = '0;
    in_ch.angle_roll = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, check on transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        poses.check_pose('{out_ch.out_pos_x, out_ch.out_pos_y, out_ch.out_pos_z,
                           out_ch.out_pitch, out_ch.out_yaw, out_ch.out_roll,
                           sib_mode_e'(out_ch.mode)});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("snapshot_interpolation_buffer_core test failed");
      $finish;
    end
  end

  task automatic write_reg(sib_reg_e idx, logic [15:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    poses.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high after a transfer; the next call idles it low or drives a new item, and drain() drops it
  task automatic send_item(logic op, logic [63:0] t, logic tv, logic [31:0] p[3],
                           logic [15:0] a[3], logic [31:0] v[3]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.time_ms <= t;
    in_ch.time_valid <= tv;
    in_ch.pos_x <= p[0];
    in_ch.pos_y <= p[1];
    in_ch.pos_z <= p[2];
    in_ch.angle_pitch <= a[0];
    in_ch.angle_yaw <= a[1];
    in_ch.angle_roll <= a[2];
    in_ch.vel_x <= v[0];
    in_ch.vel_y <= v[1];
    in_ch.vel_z <= v[2];
    do @(posedge clk_i); while (!in_ch.ready);
    poses.note_item(op, t, tv, p, a, v);
  endtask

  // Drain: wait for all poses, then cover the sequencer's worst case
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (poses.pending_poses.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(int unsigned sel);
    case (sel % 4)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Random snapshot or query near the running clock
  task automatic random_item(bit wild);
    logic [31:0] p[3], v[3];
    logic [15:0] a[3];
    logic [63:0] t;
    logic op;
    for (int j = 0; j < 3; j++) begin
      p[j] = wild ? rand_word($urandom_range(7)) : $urandom_range(200000) - 100000;
      v[j] = wild ? rand_word($urandom_range(7)) : $urandom_range(20000) - 10000;
      a[j] = 16'($urandom());
    end
    op = ($urandom_range(99) < 55) ? OP_QUERY : OP_STORE;
    if (op == OP_STORE) begin
      now_ms += $urandom_range(60);
      t = ($urandom_range(9) == 0) ? now_ms - $urandom_range(300) : now_ms;
    end else begin
      t = now_ms + $urandom_range(700) - 150;
    end
    if (wild) t = {$urandom(), $urandom()};
    send_item(op, t, $urandom_range(9) != 0, p, a, v);
  endtask

  initial begin
    logic [31:0] p[3], v[3];
    logic [15:0] a[3];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty buffer, then extremes and each query outcome
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    a = '{16'hFFFF, 16'h0000, 16'h8000};
    send_item(OP_QUERY, 64'd1000, 1'b1, p, a, v);
    send_item(OP_STORE, 64'd1000, 1'b0, p, a, v);
    a = '{16'h0001, 16'hFFFF, 16'h7FFF};
    p = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1234};
    send_item(OP_STORE, 64'd1200, 1'b0, p, a, v);
    send_item(OP_QUERY, 64'd1200, 1'b0, p, a, v);          // time invalid
    send_item(OP_QUERY, 64'd1150, 1'b1, p, a, v);          // interpolate
    send_item(OP_QUERY, 64'd1050, 1'b1, p, a, v);          // oldest still too new
    send_item(OP_QUERY, 64'd1301, 1'b1, p, a, v);          // extrapolate
    send_item(OP_QUERY, 64'd1799, 1'b1, p, a, v);
    send_item(OP_QUERY, 64'd1800, 1'b1, p, a, v);          // hold at the limit
    send_item(OP_QUERY, 64'd50, 1'b1, p, a, v);            // replay wraps
    send_item(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, p, a, v);
    send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, p, a, v);
    send_item(OP_STORE, 64'd1201, 1'b0, p, a, v);          // one past the stored 1200
    send_item(OP_QUERY, 64'd1300, 1'b1, p, a, v);
    drain();

    // Register extremes
    write_reg(REG_REPLAY_DELAY, 16'd0);
    write_reg(REG_EXTRAP_LIMIT, 16'hFFFF);
    send_item(OP_QUERY, 64'd1201, 1'b1, p, a, v);
    send_item(OP_QUERY, 64'd1201 + 64'd65534, 1'b1, p, a, v);
    drain();
    write_reg(REG_REPLAY_DELAY, 16'hFFFF);
    write_reg(REG_EXTRAP_LIMIT, 16'd0);
    send_item(OP_QUERY, 64'd70000, 1'b1, p, a, v);
    drain();
    write_reg(REG_REPLAY_DELAY, 16'd100);
    write_reg(REG_EXTRAP_LIMIT, 16'd500);

    // Random phases with changing idle patterns and settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 31 : 0;
      for (int n = 0; n < 250; n++) begin
        random_item($urandom_range(19) == 0);
        if (n == 120) drain();
      end
      drain();
      write_reg(REG_REPLAY_DELAY, 16'($urandom_range(300)));
      write_reg(REG_EXTRAP_LIMIT, 16'($urandom_range(1000)));
    end

    if (poses.errors == 0)
      $display("snapshot_interpolation_buffer_core test passed");
    else
      $display("snapshot_interpolation_buffer_core test failed");
    $finish;
  end
endmodule

`default_nettype wire

### snapshot_interpolation_buffer_core.f
+incdir+src
src/sib_pkg.sv
src/sib_ifs.sv
src/sib_queue.sv
src/sib_front.sv
src/sib_back.sv
src/snapshot_interpolation_buffer_core.sv
src/sib_checker.sv
dv/tb_sib_ifs.sv
dv/tb_snapshot_interpolation_buffer_core.sv
